@@ design/pacl_pkg.sv @@
// Package for the per-address connection limiter.
// Shared widths, status codes, reset values and parameter defaults.
// No dependencies.
`timescale 1ns / 1ps

package pacl_pkg;

	localparam int ADDR_W        = 32;
	localparam int CNT_W         = 16;
	localparam int BUCKETS_DEF   = 65536;
	localparam int WAYS_DEF      = 4;
	localparam int QUEUE_DEPTH   = 2;

	typedef logic [1:0]       status_t;
	typedef logic [CNT_W-1:0] cnt_t;

	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_OVER     = 2'd1;
	localparam status_t ST_FULL     = 2'd2;
	localparam status_t ST_NOTFOUND = 2'd3;

	localparam cnt_t LIMIT_RESET = 16'd10;

endpackage

@@ design/pacl_front.sv @@
// Front end: takes requests, splits the address into bucket and tag,
// and holds them in a short queue for the back end. Uses pacl_pkg.
`timescale 1ns / 1ps

module pacl_front #(
	parameter int BUCKETS = pacl_pkg::BUCKETS_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          in_valid,
	output logic                                          in_stall,
	input  logic                                          mode,
	input  logic [pacl_pkg::ADDR_W-1:0]                   ip_address,
	input  logic                                          store_ready,
	output logic                                          q_valid,
	input  logic                                          q_pop,
	output logic                                          q_remove,
	output logic [$clog2(BUCKETS)-1:0]                    q_bucket,
	output logic [pacl_pkg::ADDR_W-$clog2(BUCKETS)-1:0]   q_tag
);

	localparam int BUCKET_W = $clog2(BUCKETS);
	localparam int TAG_W    = pacl_pkg::ADDR_W - BUCKET_W;
	localparam int QPTR_W   = (pacl_pkg::QUEUE_DEPTH > 1) ? $clog2(pacl_pkg::QUEUE_DEPTH) : 1;
	localparam int QCNT_W   = $clog2(pacl_pkg::QUEUE_DEPTH + 1);

	logic                 rem_q    [pacl_pkg::QUEUE_DEPTH];
	logic [BUCKET_W-1:0]  bucket_q [pacl_pkg::QUEUE_DEPTH];
	logic [TAG_W-1:0]     tag_q    [pacl_pkg::QUEUE_DEPTH];
	logic [QPTR_W-1:0]    wr_ptr_q;
	logic [QPTR_W-1:0]    rd_ptr_q;
	logic [QCNT_W-1:0]    fill_q;
	logic                 push;
	logic                 full;

	assign full     = (fill_q == QCNT_W'(pacl_pkg::QUEUE_DEPTH));
	assign in_stall = !store_ready || full;
	assign push     = in_valid && !in_stall;
	assign q_valid  = (fill_q != '0);
	assign q_remove = rem_q[rd_ptr_q];
	assign q_bucket = bucket_q[rd_ptr_q];
	assign q_tag    = tag_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			rem_q[wr_ptr_q]    <= mode;
			bucket_q[wr_ptr_q] <= ip_address[BUCKET_W-1:0];
			tag_q[wr_ptr_q]    <= ip_address[pacl_pkg::ADDR_W-1:BUCKET_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(pacl_pkg::QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + QPTR_W'(1);
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(pacl_pkg::QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + QPTR_W'(1);
			end
			if (push && !q_pop) begin
				fill_q <= fill_q + QCNT_W'(1);
			end else if (!push && q_pop) begin
				fill_q <= fill_q - QCNT_W'(1);
			end
		end
	end

endmodule

@@ design/pacl_back.sv @@
// Back end: bucket store with its reset clearing sweep, limit register,
// read-modify-write of one bucket row, and the result register. Uses pacl_pkg.
`timescale 1ns / 1ps

module pacl_back #(
	parameter int BUCKETS = pacl_pkg::BUCKETS_DEF,
	parameter int WAYS    = pacl_pkg::WAYS_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          cfg_wr_en,
	input  logic [pacl_pkg::CNT_W-1:0]                    cfg_wr_data,
	output logic                                          store_ready,
	input  logic                                          q_valid,
	output logic                                          q_pop,
	input  logic                                          q_remove,
	input  logic [$clog2(BUCKETS)-1:0]                    q_bucket,
	input  logic [pacl_pkg::ADDR_W-$clog2(BUCKETS)-1:0]   q_tag,
	output logic                                          out_valid,
	input  logic                                          out_stall,
	output pacl_pkg::status_t                             status,
	output pacl_pkg::cnt_t                                count
);

	localparam int BUCKET_W = $clog2(BUCKETS);
	localparam int TAG_W    = pacl_pkg::ADDR_W - BUCKET_W;
	localparam int CNT_W    = pacl_pkg::CNT_W;
	localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int ROW_W    = WAYS * (1 + TAG_W + CNT_W);

	logic [ROW_W-1:0] mem [BUCKETS];

	logic [BUCKET_W-1:0]  clr_idx_q;
	logic                 clr_busy_q;
	logic                 exec_q;
	pacl_pkg::cnt_t       limit_q;
	logic                 out_valid_q;
	pacl_pkg::status_t    status_q;
	pacl_pkg::cnt_t       count_q;

	logic                 rem_s1;
	logic [BUCKET_W-1:0]  bucket_s1;
	logic [TAG_W-1:0]     tag_s1;
	logic [ROW_W-1:0]     row_s1;

	logic [WAYS-1:0]             rd_vld;
	logic [WAYS-1:0][TAG_W-1:0]  rd_tag;
	logic [WAYS-1:0][CNT_W-1:0]  rd_cnt;
	logic [WAYS-1:0]             wr_vld;
	logic [WAYS-1:0][TAG_W-1:0]  wr_tag;
	logic [WAYS-1:0][CNT_W-1:0]  wr_cnt;

	logic [WAYS-1:0]   hit_vec;
	logic [WAYS-1:0]   free_vec;
	logic [WAY_W-1:0]  hit_idx;
	logic [WAY_W-1:0]  free_idx;
	pacl_pkg::cnt_t    hit_cnt;
	pacl_pkg::cnt_t    dec_cnt;
	pacl_pkg::status_t res_status;
	pacl_pkg::cnt_t    res_count;

	logic                 mem_we;
	logic [BUCKET_W-1:0]  mem_waddr;
	logic [ROW_W-1:0]     mem_wdata;

	assign store_ready = !clr_busy_q;
	assign q_pop       = q_valid && !exec_q && !clr_busy_q && (!out_valid_q || !out_stall);
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign count       = count_q;

	assign {rd_vld, rd_tag, rd_cnt} = row_s1;

	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		for (int w = 0; w < WAYS; w++) begin
			hit_vec[w]  = rd_vld[w] && (rd_tag[w] == tag_s1);
			free_vec[w] = !rd_vld[w];
		end
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (hit_vec[w]) hit_idx = WAY_W'(w);
			if (free_vec[w]) free_idx = WAY_W'(w);
		end
	end

	assign hit_cnt = rd_cnt[hit_idx];
	assign dec_cnt = (hit_cnt != '0) ? hit_cnt - CNT_W'(1) : '0;

	always_comb begin
		wr_vld     = rd_vld;
		wr_tag     = rd_tag;
		wr_cnt     = rd_cnt;
		res_status = pacl_pkg::ST_OK;
		res_count  = '0;
		if (!rem_s1) begin
			if (hit_vec != '0) begin
				if (hit_cnt >= limit_q) begin
					res_status = pacl_pkg::ST_OVER;
					res_count  = hit_cnt;
				end else begin
					wr_cnt[hit_idx] = hit_cnt + CNT_W'(1);
					res_count       = hit_cnt + CNT_W'(1);
				end
			end else if (free_vec == '0) begin
				res_status = pacl_pkg::ST_FULL;
			end else begin
				wr_vld[free_idx] = 1'b1;
				wr_tag[free_idx] = tag_s1;
				wr_cnt[free_idx] = CNT_W'(1);
				res_count        = CNT_W'(1);
			end
		end else begin
			if (hit_vec == '0) begin
				res_status = pacl_pkg::ST_NOTFOUND;
			end else if (dec_cnt == '0) begin
				wr_vld[hit_idx] = 1'b0;
				wr_tag[hit_idx] = '0;
				wr_cnt[hit_idx] = '0;
			end else begin
				wr_cnt[hit_idx] = dec_cnt;
				res_count       = dec_cnt;
			end
		end
	end

	assign mem_we    = clr_busy_q || exec_q;
	assign mem_waddr = clr_busy_q ? clr_idx_q : bucket_s1;
	assign mem_wdata = clr_busy_q ? '0 : {wr_vld, wr_tag, wr_cnt};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (q_pop) begin
			row_s1    <= mem[q_bucket];
			rem_s1    <= q_remove;
			bucket_s1 <= q_bucket;
			tag_s1    <= q_tag;
		end
		if (exec_q) begin
			status_q <= res_status;
			count_q  <= res_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q   <= '0;
			clr_busy_q  <= 1'b1;
			exec_q      <= 1'b0;
			limit_q     <= pacl_pkg::LIMIT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
			if (clr_busy_q) begin
				clr_idx_q <= clr_idx_q + BUCKET_W'(1);
				if (clr_idx_q == BUCKET_W'(BUCKETS - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			exec_q <= q_pop;
			if (exec_q) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// one row update in flight, never back to back on the single port
	a_exec_gap: assert property (@(posedge clk) disable iff (!arst_n)
		exec_q |=> !exec_q)
		else $error("back-to-back row updates");

	// result slot must be free when a result lands
	a_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		exec_q |-> !out_valid_q)
		else $error("result overwrites pending request");

	// clearing sweep owns the store
	a_clr_excl: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !exec_q && !q_pop)
		else $error("store access during clearing sweep");

	a_clr_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clr_busy_q) |-> $past(clr_idx_q) == BUCKET_W'(BUCKETS - 1))
		else $error("clearing sweep ended early");

endmodule

@@ design/per_address_connection_limiter.sv @@
// Top level of the per-address connection limiter.
// Instantiates pacl_front and pacl_back; uses pacl_pkg.
//
// channel   direction  handshake             payload
// in        to block   in_valid / in_stall   mode, ip_address
// out       from block out_valid / out_stall status, count
// cfg       to block   cfg_wr_en             cfg_wr_data (connection_limit)
//
// A bucket row is read, then updated, on the one store port before the next is read.
// A request passes in turn the queue, the row read register and the result register.
// After reset a sweep clearing all BUCKETS rows (65536 by default) holds in_stall high.
// A two-entry queue keeps taking requests until full while out_stall holds a result.
// BUCKETS must be a power of two.
`timescale 1ns / 1ps

module per_address_connection_limiter #(
	parameter int BUCKETS = pacl_pkg::BUCKETS_DEF,
	parameter int WAYS    = pacl_pkg::WAYS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          mode,
	input  logic [pacl_pkg::ADDR_W-1:0]   ip_address,
	output logic                          out_valid,
	input  logic                          out_stall,
	output pacl_pkg::status_t             status,
	output pacl_pkg::cnt_t                count,
	input  logic                          cfg_wr_en,
	input  logic [pacl_pkg::CNT_W-1:0]    cfg_wr_data
);

	localparam int BUCKET_W = $clog2(BUCKETS);
	localparam int TAG_W    = pacl_pkg::ADDR_W - BUCKET_W;

	logic                 store_ready;
	logic                 q_valid;
	logic                 q_pop;
	logic                 q_remove;
	logic [BUCKET_W-1:0]  q_bucket;
	logic [TAG_W-1:0]     q_tag;

	pacl_front #(
		.BUCKETS(BUCKETS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.ip_address (ip_address),
		.store_ready(store_ready),
		.q_valid    (q_valid),
		.q_pop      (q_pop),
		.q_remove   (q_remove),
		.q_bucket   (q_bucket),
		.q_tag      (q_tag)
	);

	pacl_back #(
		.BUCKETS(BUCKETS),
		.WAYS   (WAYS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.store_ready(store_ready),
		.q_valid    (q_valid),
		.q_pop      (q_pop),
		.q_remove   (q_remove),
		.q_bucket   (q_bucket),
		.q_tag      (q_tag),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.count      (count)
	);

endmodule
